[design/htw_pkg.sv]
`default_nettype none

package htw_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int TASKS_DEF       = 32;
  localparam int PERIOD_BITS_DEF = 16;

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_ZERO_PERIOD = 2'd1;
  localparam logic [1:0] STAT_ARMED       = 2'd2;
  localparam logic [1:0] STAT_NOT_ARMED   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  task_id;
    logic [15:0] period;
  } htw_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [4:0] fired_task;
    logic       last;
  } htw_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PLACE,
    S_SCAN,
    S_FLUSH
  } htw_state_t;

endpackage

`default_nettype wire

[design/hashed_timer_wheel_core.sv]
// Channel   Ports                 Handshake
// --------  --------------------  -------------------------------------------
// command   cmd (htw_in_t)        taken at an edge with start high, busy low
// result    result (htw_out_t)    valid for one cycle while strobe is high
//
// Arm of a free id with a nonzero period: busy in S_DIV (quotient by SLOTS
// through a reciprocal multiply), then S_PLACE (the entry write); word in the next cycle.
// Arm rejects, cancel and unused codes: not busy; word in the cycle after.
// Tick: busy through S_SCAN, one entry RAM read per cycle, then S_FLUSH;
// fired words stream out during the scan, the final word once busy drops.
// Reset is synchronous; no clearing pass. Results cannot be held off.
`default_nettype none

module hashed_timer_wheel_core
  import htw_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int TASKS       = TASKS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire htw_in_t  cmd,
  output logic          strobe,
  output htw_out_t      result
);

  localparam int PB  = PERIOD_BITS;
  localparam int SB  = $clog2(SLOTS);
  localparam longint unsigned MAX_PER = (64'd1 << PERIOD_BITS) - 64'd1;
  localparam int RB_RAW = $clog2(MAX_PER / SLOTS + 1);
  localparam int RB  = (RB_RAW < 1) ? 1 : RB_RAW;
  localparam int IB  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW  = $clog2(TASKS + 1);
  // floor(n / SLOTS) = (n * RECIP) >> QS for every n below 2**PB
  localparam int QS  = PB + SB;
  localparam longint unsigned RECIP =
      ((64'd1 << QS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  typedef struct packed {
    logic [SB-1:0] slot;
    logic [RB-1:0] rounds;
    logic [RB-1:0] rinit;   // period div SLOTS
    logic [SB-1:0] pmod;    // period mod SLOTS
  } entry_t;

  localparam int EW = $bits(entry_t);

  htw_state_t state, state_next;

  logic [SB-1:0]    pos;
  logic [TASKS-1:0] valid;
  logic [TASKS-1:0] live;

  logic [IB-1:0]  a_idx;
  logic [PB-1:0]  div_per;
  logic [RB-1:0]  div_q;

  logic [CW-1:0]  scan_cnt;
  logic           p_vld;
  logic [IB-1:0]  p_idx;
  logic           pend_vld;
  logic [IB-1:0]  pend_task;

  logic           strobe_next;
  htw_out_t       result_next;

  // command decode
  logic [PB-1:0] in_per;
  logic [IB-1:0] in_idx;
  logic          id_ok;
  logic          accept;
  logic          arm_go;
  logic          cancel_go;
  logic [1:0]    cmd_status;

  assign in_per    = PB'(cmd.period);
  assign in_idx    = IB'(cmd.task_id);
  assign id_ok     = 32'(cmd.task_id) < 32'(TASKS);
  assign accept    = start && !busy;
  assign arm_go    = (cmd.operation == OP_ARM) && (in_per != '0) && id_ok && !valid[in_idx];
  assign cancel_go = id_ok && valid[in_idx] && live[in_idx];

  always_comb begin
    cmd_status = STAT_OK;
    if (cmd.operation == OP_ARM) begin
      if (in_per == '0) begin
        cmd_status = STAT_ZERO_PERIOD;
      end else if (!id_ok) begin
        cmd_status = STAT_NOT_ARMED;
      end else if (valid[in_idx]) begin
        cmd_status = STAT_ARMED;
      end
    end else if (cmd.operation == OP_CANCEL) begin
      if (!cancel_go) begin
        cmd_status = STAT_NOT_ARMED;
      end
    end
  end

  // quotient by reciprocal multiply; remainder only needs the low SB bits
  logic [2*PB:0] div_prod;
  logic [RB-1:0] div_quot;
  logic [SB-1:0] place_rem;

  assign div_prod  = (2*PB+1)'(div_per) * (2*PB+1)'(RECIP);
  assign div_quot  = RB'(div_prod >> QS);
  assign place_rem = SB'(div_per) - SB'(SB'(div_q) * SB'(SLOTS));

  // shared slot adder: (pos + period mod SLOTS) mod SLOTS
  entry_t        rd;
  logic [EW-1:0] ram_rdata;
  logic [SB-1:0] add_b;
  logic [SB:0]   slot_sum;
  logic [SB-1:0] slot_new;

  assign rd       = ram_rdata;
  assign add_b    = (state == S_PLACE) ? place_rem : rd.pmod;
  assign slot_sum = {1'b0, pos} + {1'b0, add_b};
  assign slot_new = (slot_sum >= (SB+1)'(SLOTS)) ? SB'(slot_sum - (SB+1)'(SLOTS))
                                                  : SB'(slot_sum);

  // scan evaluation of the entry read last cycle
  logic hit;
  logic rzero;
  logic fire;

  assign hit   = p_vld && valid[p_idx] && (rd.slot == pos);
  assign rzero = (rd.rounds == '0);
  assign fire  = hit && rzero && live[p_idx];

  logic [IB-1:0] ram_raddr;
  logic          ram_we;
  logic [IB-1:0] ram_waddr;
  entry_t        ram_wdata;

  assign ram_raddr = scan_cnt[IB-1:0];

  htw_ram #(
    .WIDTH (EW),
    .DEPTH (TASKS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (arm_go) begin
            state_next = S_DIV;
          end else if (cmd.operation == OP_TICK) begin
            state_next = S_SCAN;
          end
        end
      end
      S_DIV: state_next = S_PLACE;
      S_PLACE: state_next = S_IDLE;
      S_SCAN: begin
        if (scan_cnt == CW'(TASKS)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy        = (state != S_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = p_idx;
    ram_wdata   = rd;
    strobe_next = 1'b0;
    result_next = '{status: STAT_OK, fired: 1'b0, fired_task: 5'd0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next        = !arm_go && (cmd.operation != OP_TICK);
          result_next.status = cmd_status;
        end
      end
      S_PLACE: begin
        ram_we      = 1'b1;
        ram_waddr   = a_idx;
        ram_wdata   = '{slot: slot_new, rounds: div_q, rinit: div_q, pmod: place_rem};
        strobe_next = 1'b1;
      end
      S_SCAN: begin
        // dead expired entries are only freed, never written
        ram_we = hit && !(rzero && !live[p_idx]);
        if (rzero) begin
          ram_wdata = '{slot: slot_new, rounds: rd.rinit, rinit: rd.rinit, pmod: rd.pmod};
        end else begin
          ram_wdata = '{slot: rd.slot, rounds: rd.rounds - RB'(1), rinit: rd.rinit,
                        pmod: rd.pmod};
        end
        // a fired word is held until the next one shows it was not last
        if (fire && pend_vld) begin
          strobe_next = 1'b1;
          result_next = '{status: STAT_OK, fired: 1'b1, fired_task: 5'(pend_task),
                          last: 1'b0};
        end
      end
      S_FLUSH: begin
        strobe_next = 1'b1;
        if (pend_vld) begin
          result_next = '{status: STAT_OK, fired: 1'b1, fired_task: 5'(pend_task),
                          last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      valid    <= '0;
      live     <= '0;
      strobe   <= 1'b0;
      p_vld    <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      result <= result_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            a_idx   <= in_idx;
            div_per <= in_per;
            if (cmd.operation == OP_CANCEL && cancel_go) begin
              live[in_idx] <= 1'b0;
            end
            if (cmd.operation == OP_TICK) begin
              scan_cnt <= '0;
              p_vld    <= 1'b0;
              pend_vld <= 1'b0;
            end
          end
        end
        S_DIV: begin
          div_q <= div_quot;
        end
        S_PLACE: begin
          valid[a_idx] <= 1'b1;
          live[a_idx]  <= 1'b1;
        end
        S_SCAN: begin
          if (scan_cnt != CW'(TASKS)) begin
            p_vld    <= 1'b1;
            p_idx    <= scan_cnt[IB-1:0];
            scan_cnt <= scan_cnt + CW'(1);
          end else begin
            p_vld <= 1'b0;
          end
          if (fire) begin
            pend_vld  <= 1'b1;
            pend_task <= p_idx;
          end else if (hit && rzero) begin
            valid[p_idx] <= 1'b0;
          end
        end
        S_FLUSH: begin
          pend_vld <= 1'b0;
          pos      <= (pos == SB'(SLOTS - 1)) ? '0 : pos + SB'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/htw_ram.sv]
`default_nettype none

module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import htw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = TASKS_DEF + 8;
  localparam int IN_W = $bits(htw_in_t);

  typedef struct packed {
    logic [6:0] gap_pct;
    htw_in_t    word;
  } queued_cmd_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  htw_in_t  cmd = '0;
  logic     strobe;
  htw_out_t result;

  hashed_timer_wheel_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the wheel
  logic [5:0]  wheel_pos;
  logic        task_valid [TASKS_DEF];
  logic        task_live  [TASKS_DEF];
  logic [5:0]  task_slot  [TASKS_DEF];
  logic [9:0]  task_rounds[TASKS_DEF];
  logic [15:0] task_period[TASKS_DEF];

  queued_cmd_t cmd_queue[$];
  htw_out_t    expected_reports[$];
  htw_out_t    want;
  int          words_queued = 0;
  int          words_accepted = 0;
  int          errors = 0;
  int          cycle_count = 0;

  task automatic add_expected(input htw_out_t r);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic place_task(input int idx, input logic [15:0] per);
    task_slot[idx]   = 6'((int'(wheel_pos) + int'(per)) % SLOTS_DEF);
    task_rounds[idx] = 10'(int'(per) / SLOTS_DEF);
    task_period[idx] = per;
  endtask

  task automatic predict_reports(input htw_in_t w);
    htw_out_t r;
    logic [TASKS_DEF-1:0] fired_mask;
    int i;
    int last_idx;
    r = '0;
    r.last = 1'b1;
    fired_mask = '0;
    last_idx = -1;
    case (w.operation)
      OP_ARM: begin
        if (w.period == '0) begin
          r.status = STAT_ZERO_PERIOD;
        end else if (task_valid[w.task_id]) begin
          r.status = STAT_ARMED;
        end else begin
          task_valid[w.task_id] = 1'b1;
          task_live[w.task_id] = 1'b1;
          place_task(int'(w.task_id), w.period);
          r.status = STAT_OK;
        end
        add_expected(r);
      end
      OP_CANCEL: begin
        r.status = STAT_NOT_ARMED;
        if (task_valid[w.task_id] && task_live[w.task_id]) begin
          task_live[w.task_id] = 1'b0;
          r.status = STAT_OK;
        end
        add_expected(r);
      end
      OP_TICK: begin
        for (i = 0; i < TASKS_DEF; i++) begin
          if (task_valid[i] && task_slot[i] == wheel_pos) begin
            if (task_rounds[i] == '0) begin
              if (task_live[i]) begin
                place_task(i, task_period[i]);
                fired_mask[i] = 1'b1;
                last_idx = i;
              end else begin
                task_valid[i] = 1'b0;
              end
            end else begin
              task_rounds[i] = task_rounds[i] - 10'd1;
            end
          end
        end
        wheel_pos = wheel_pos + 6'd1;
        if (last_idx < 0) begin
          add_expected(r);
        end else begin
          for (i = 0; i < TASKS_DEF; i++) begin
            if (fired_mask[i]) begin
              r.status = STAT_OK;
              r.fired = 1'b1;
              r.fired_task = 5'(i);
              r.last = (i == last_idx);
              add_expected(r);
            end
          end
        end
      end
      default: begin
        add_expected(r);
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [1:0] op, input int id, input int per,
                           input int gap);
    queued_cmd_t q;
    q.gap_pct = 7'(gap);
    q.word.operation = op;
    q.word.task_id = 5'(id);
    q.word.period = 16'(per);
    cmd_queue.insert(cmd_queue.size(), q);
    words_queued++;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst && cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].gap_pct) begin
      start <= 1'b1;
      cmd <= cmd_queue[0].word;
    end else begin
      start <= 1'b0;
      cmd <= IN_W'($urandom);
    end
  end

  // monitor: predict on acceptance, then check the result; results are registered, so no word answers as it is accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_reports(cmd);
        cmd_queue.delete(0);
        words_accepted++;
      end
      if (strobe) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result status %0d fired %0d task %0d last %0d",
                   $time, result.status, result.fired, result.fired_task, result.last);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (result.status !== want.status || result.fired !== want.fired ||
              result.fired_task !== want.fired_task || result.last !== want.last) begin
            $display("%0t: expected st %0d f %0d t %0d l %0d, got st %0d f %0d t %0d l %0d",
                     $time, want.status, want.fired, want.fired_task, want.last,
                     result.status, result.fired, result.fired_task, result.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int gaps[4];
    int ph;
    int n;
    int sel;
    int id;
    int per;
    logic [1:0] op;

    wheel_pos = '0;
    for (n = 0; n < TASKS_DEF; n++) begin
      task_valid[n] = 1'b0;
      task_live[n] = 1'b0;
      task_slot[n] = '0;
      task_rounds[n] = '0;
      task_period[n] = '0;
    end
    gaps[0] = 0;
    gaps[1] = 56;
    gaps[2] = 0;
    gaps[3] = 13;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: rejects, reuse of a cancelled id, multi-fire ticks, dead entry freeing
    queue_cmd(OP_ARM, 0, 0, 0);
    queue_cmd(OP_ARM, 0, 1, 0);
    queue_cmd(OP_ARM, 0, 5, 0);
    queue_cmd(OP_CANCEL, 1, 0, 0);
    queue_cmd(OP_ARM, 31, 65535, 0);
    queue_cmd(OP_ARM, 1, 64, 0);
    queue_cmd(OP_ARM, 2, 2, 0);
    queue_cmd(OP_CANCEL, 2, 0, 0);
    queue_cmd(OP_CANCEL, 2, 0, 0);
    queue_cmd(OP_ARM, 2, 3, 0);
    queue_cmd(OP_UNUSED, 17, 43690, 0);
    queue_cmd(OP_ARM, 3, 1, 0);
    queue_cmd(OP_ARM, 4, 1, 0);
    queue_cmd(OP_CANCEL, 31, 0, 0);
    queue_cmd(OP_TICK, 0, 0, 0);
    queue_cmd(OP_TICK, 31, 65535, 0);
    queue_cmd(OP_TICK, 0, 0, 0);
    queue_cmd(OP_ARM, 2, 1, 0);
    queue_cmd(OP_CANCEL, 3, 0, 0);
    queue_cmd(OP_TICK, 0, 0, 0);
    queue_cmd(OP_TICK, 0, 0, 0);
    queue_cmd(OP_ARM, 5, 21845, 0);

    for (ph = 0; ph < 4; ph++) begin
      for (n = 0; n < 72; n++) begin
        sel = $urandom_range(99);
        if (sel < 45) op = OP_TICK;
        else if (sel < 80) op = OP_ARM;
        else if (sel < 95) op = OP_CANCEL;
        else op = OP_UNUSED;
        id = $urandom_range(1) ? $urandom_range(7) : $urandom_range(31);
        sel = $urandom_range(99);
        if (sel < 5) per = 0;
        else if (sel < 60) per = $urandom_range(12, 1);
        else if (sel < 85) per = $urandom_range(130, 13);
        else per = $urandom_range(65535);
        queue_cmd(op, id, per, gaps[ph]);
      end
    end

    wait (words_accepted == words_queued);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/htw_pkg.sv
design/htw_ram.sv
design/hashed_timer_wheel_core.sv
tb/testbench.sv
